// ----- sv/i2cms_pkg.sv -----
`default_nettype none
package i2cms_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ST_REL  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ST_SDA  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ST_SCL  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SP_HI   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SP_REL  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_STRETCH = 4'd6;
    localparam logic [PHASE_W-1:0] PH_HIGH    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LOW1    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_LOW2    = 4'd9;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_START = 2'd0;
    localparam t_mode MODE_STOP  = 2'd1;
    localparam t_mode MODE_WRITE = 2'd2;
    localparam t_mode MODE_READ  = 2'd3;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [3:0]  BITS_WRITE        = 4'd8;
    localparam logic [3:0]  BITS_READ         = 4'd9;
    localparam logic [3:0]  LAST_DATA_BIT     = 4'd7;

endpackage
`default_nettype wire

// ----- sv/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer for an open-drain bus. Every input transaction is one bus tick
// carrying the sampled SCL/SDA levels and optionally a command (start, stop, write byte,
// read byte with ack/nack); each tick yields exactly one result transaction with the line
// drives, busy flag, last read byte and a done pulse. One tick is handled per clock cycle:
// the sequencer state advances in the cycle a tick is accepted and the result is held in
// the output register, so a new tick is taken every cycle the result slot is free or
// being drained. Commands arriving while busy are ignored. Every delay point lasts
// half_period_ticks ticks (0 counts as 1); before each bit's high phase the sequencer
// waits for SCL to read high, so a slave may stretch the clock without limit.
`default_nettype none
module i2c_master_bit_sequencer #(
    parameter int DELAY_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd_valid,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_send_ack,
    input  wire logic        i_scl_in,
    input  wire logic        i_sda_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl_drive_low,
    output logic             o_sda_drive_low,
    output logic             o_busy_res,
    output logic [7:0]       o_read_data,
    output logic             o_cmd_done
);

    localparam int PW = i2cms_pkg::PHASE_W;

    logic [15:0]            r_half;
    logic [PW-1:0]          r_phase,  n_phase;
    logic [3:0]             r_bit,    n_bit;
    logic [7:0]             r_shift,  n_shift;
    logic [DELAY_WIDTH-1:0] r_wait,   n_wait;
    i2cms_pkg::t_mode       r_mode,   n_mode;
    logic                   r_ack,    n_ack;
    logic                   r_scl_low, n_scl_low;
    logic                   r_sda_low, n_sda_low;
    logic [7:0]             r_last,   n_last;
    logic                   r_done,   n_done;
    logic                   r_out_valid;

    logic                   accept;
    logic [47:0]            half_ext;
    logic [DELAY_WIDTH-1:0] load_val;
    logic                   over;
    logic [DELAY_WIDTH-1:0] wait_dec;
    logic                   do_begin;
    logic                   do_next;
    logic [3:0]             bit_inc;
    logic                   cur_read_bit;
    logic                   cur_wbv;
    logic                   beg_read_bit;
    logic                   beg_wbv;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign half_ext = {32'd0, r_half};
    assign load_val = (half_ext[DELAY_WIDTH-1:0] == '0) ? DELAY_WIDTH'(1)
                                                         : half_ext[DELAY_WIDTH-1:0];
    assign over     = (r_wait <= DELAY_WIDTH'(1));
    assign wait_dec = over ? '0 : r_wait - DELAY_WIDTH'(1);
    assign bit_inc  = r_bit + 4'd1;

    assign cur_read_bit = (r_mode == i2cms_pkg::MODE_READ) && (r_bit < i2cms_pkg::BITS_WRITE);
    assign cur_wbv      = (r_mode == i2cms_pkg::MODE_READ) ? !r_ack : r_shift[7];

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_mode    = r_mode;
        n_ack     = r_ack;
        n_scl_low = r_scl_low;
        n_sda_low = r_sda_low;
        n_last    = r_last;
        n_done    = 1'b0;
        do_begin  = 1'b0;
        do_next   = 1'b0;

        unique case (r_phase)
            i2cms_pkg::PH_IDLE: begin
                if (i_cmd_valid) begin
                    n_mode = i_mode;
                    n_ack  = i_send_ack;
                    n_bit  = 4'd0;
                    unique case (i_mode)
                        i2cms_pkg::MODE_START: begin
                            n_scl_low = 1'b0;
                            n_sda_low = 1'b0;
                            n_wait    = load_val;
                            n_phase   = i2cms_pkg::PH_ST_REL;
                        end
                        i2cms_pkg::MODE_STOP: begin
                            n_scl_low = 1'b0;
                            n_sda_low = 1'b1;
                            n_wait    = load_val;
                            n_phase   = i2cms_pkg::PH_SP_HI;
                        end
                        default: begin
                            n_shift  = (i_mode == i2cms_pkg::MODE_WRITE) ? i_write_data : 8'd0;
                            do_begin = 1'b1;
                        end
                    endcase
                end
            end
            i2cms_pkg::PH_ST_REL: begin
                n_wait = wait_dec;
                if (over) begin
                    n_sda_low = 1'b1;
                    n_wait    = load_val;
                    n_phase   = i2cms_pkg::PH_ST_SDA;
                end
            end
            i2cms_pkg::PH_ST_SDA: begin
                n_wait = wait_dec;
                if (over) begin
                    n_scl_low = 1'b1;
                    n_wait    = load_val;
                    n_phase   = i2cms_pkg::PH_ST_SCL;
                end
            end
            i2cms_pkg::PH_ST_SCL, i2cms_pkg::PH_SP_REL: begin
                n_wait = wait_dec;
                if (over) begin
                    n_phase = i2cms_pkg::PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            i2cms_pkg::PH_SP_HI: begin
                n_wait = wait_dec;
                if (over) begin
                    n_sda_low = 1'b0;
                    n_wait    = load_val;
                    n_phase   = i2cms_pkg::PH_SP_REL;
                end
            end
            i2cms_pkg::PH_STRETCH: begin
                // hold until the slave lets go of SCL
                if (i_scl_in) begin
                    n_wait  = load_val;
                    n_phase = i2cms_pkg::PH_HIGH;
                end
            end
            i2cms_pkg::PH_HIGH: begin
                n_wait = wait_dec;
                if (over) begin
                    if (cur_read_bit) begin
                        n_shift = {r_shift[6:0], i_sda_in};
                        if (r_bit == i2cms_pkg::LAST_DATA_BIT) begin
                            n_last = {r_shift[6:0], i_sda_in};
                        end
                    end
                    n_scl_low = 1'b1;
                    n_wait    = load_val;
                    n_phase   = i2cms_pkg::PH_LOW1;
                end
            end
            i2cms_pkg::PH_LOW1: begin
                n_wait = wait_dec;
                if (over) begin
                    if (cur_read_bit) begin
                        do_next = 1'b1;
                    end else begin
                        if (cur_wbv) begin
                            n_sda_low = 1'b1;
                        end
                        n_wait  = load_val;
                        n_phase = i2cms_pkg::PH_LOW2;
                    end
                end
            end
            i2cms_pkg::PH_LOW2: begin
                n_wait = wait_dec;
                if (over) begin
                    if (r_mode == i2cms_pkg::MODE_WRITE) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                    do_next = 1'b1;
                end
            end
            default: begin
                n_phase = i2cms_pkg::PH_IDLE;
            end
        endcase

        // advance to the next bit, or finish once the byte (and ack) is out
        if (do_next) begin
            n_bit = bit_inc;
            if (bit_inc >= ((r_mode == i2cms_pkg::MODE_READ) ? i2cms_pkg::BITS_READ
                                                             : i2cms_pkg::BITS_WRITE)) begin
                n_phase = i2cms_pkg::PH_IDLE;
                n_done  = 1'b1;
            end else begin
                do_begin = 1'b1;
            end
        end

        if (do_begin) begin
            n_sda_low = beg_read_bit ? 1'b0 : !beg_wbv;
            n_scl_low = 1'b0;
            n_phase   = i2cms_pkg::PH_STRETCH;
        end
    end

    // bit setup sees the mode, count and shift value as updated this tick
    always_comb begin
        beg_read_bit = 1'b0;
        beg_wbv      = 1'b0;
        if (r_phase == i2cms_pkg::PH_IDLE) begin
            beg_read_bit = (i_mode == i2cms_pkg::MODE_READ);
            beg_wbv      = (i_mode == i2cms_pkg::MODE_READ) ? !i_send_ack : i_write_data[7];
        end else begin
            beg_read_bit = (r_mode == i2cms_pkg::MODE_READ) && (bit_inc < i2cms_pkg::BITS_WRITE);
            beg_wbv      = (r_mode == i2cms_pkg::MODE_READ) ? !r_ack : n_shift[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= i2cms_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cms_pkg::PH_IDLE;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_wait      <= '0;
            r_mode      <= i2cms_pkg::MODE_START;
            r_ack       <= 1'b0;
            r_scl_low   <= 1'b0;
            r_sda_low   <= 1'b0;
            r_last      <= 8'd0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_wait    <= n_wait;
                r_mode    <= n_mode;
                r_ack     <= n_ack;
                r_scl_low <= n_scl_low;
                r_sda_low <= n_sda_low;
                r_last    <= n_last;
                r_done    <= n_done;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state only moves when a new result is loaded, so it doubles as the result register
    assign o_out_valid     = r_out_valid;
    assign o_scl_drive_low = r_scl_low;
    assign o_sda_drive_low = r_sda_low;
    assign o_busy_res      = (r_phase != i2cms_pkg::PH_IDLE);
    assign o_read_data     = r_last;
    assign o_cmd_done      = r_done;

endmodule
`default_nettype wire

// ----- sv/i2cms_checker.sv -----
`default_nettype none
module i2cms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_scl_drive_low,
    input wire logic       o_sda_drive_low,
    input wire logic       o_busy_res,
    input wire logic [7:0] o_read_data,
    input wire logic       o_cmd_done
);

    logic       out_xfer;
    logic       r_prev_busy;
    logic       r_prev_scl;
    logic       r_prev_sda;
    logic [7:0] r_prev_read;

    assign out_xfer = o_out_valid && i_out_ready;

    // track the last delivered result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_busy <= 1'b0;
            r_prev_scl  <= 1'b0;
            r_prev_sda  <= 1'b0;
            r_prev_read <= 8'd0;
        end else if (out_xfer) begin
            r_prev_busy <= o_busy_res;
            r_prev_scl  <= o_scl_drive_low;
            r_prev_sda  <= o_sda_drive_low;
            r_prev_read <= o_read_data;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cmd_done |-> !o_busy_res)
        else $error("done reported while still busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cmd_done |-> r_prev_busy)
        else $error("done without a sequence in progress");

    a_read_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_prev_busy |-> o_read_data == r_prev_read)
        else $error("read byte changed while idle");

    a_idle_lines_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_prev_busy && !o_busy_res
        |-> o_scl_drive_low == r_prev_scl && o_sda_drive_low == r_prev_sda)
        else $error("line drives moved while idle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
        && $stable(o_busy_res) && $stable(o_cmd_done))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_scl_drive_low (o_scl_drive_low),
    .o_sda_drive_low (o_sda_drive_low),
    .o_busy_res      (o_busy_res),
    .o_read_data     (o_read_data),
    .o_cmd_done      (o_cmd_done)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // level the slave puts on SDA while a command runs
    localparam logic [1:0] SDA_LOW  = 2'd0;
    localparam logic [1:0] SDA_HIGH = 2'd1;
    localparam logic [1:0] SDA_RAND = 2'd2;

    typedef struct packed {
        logic                cmd_valid;
        i2cms_pkg::t_mode    mode;
        logic [7:0]          wdata;
        logic                send_ack;
        logic                scl;
        logic                sda;
    } t_tick;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic [7:0] rdata;
        logic       done;
    } t_bus_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd_valid = 1'b0;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_write_data = '0;
    logic        i_send_ack = 1'b0;
    logic        i_scl_in = 1'b1;
    logic        i_sda_in = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_scl_drive_low;
    logic        o_sda_drive_low;
    logic        o_busy_res;
    logic [7:0]  o_read_data;
    logic        o_cmd_done;

    i2c_master_bit_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd_valid     (i_cmd_valid),
        .i_mode          (i_mode),
        .i_write_data    (i_write_data),
        .i_send_ack      (i_send_ack),
        .i_scl_in        (i_scl_in),
        .i_sda_in        (i_sda_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scl_drive_low (o_scl_drive_low),
        .o_sda_drive_low (o_sda_drive_low),
        .o_busy_res      (o_busy_res),
        .o_read_data     (o_read_data),
        .o_cmd_done      (o_cmd_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_tick    tick_q[$];
    t_bus_res bus_res_q[$];
    t_tick    cur_tick;
    int       send_idle_pct = 22;
    int       recv_idle_pct = 82;
    int       mismatches = 0;
    int       cycles = 0;
    logic     rx_hold = 1'b0;
    logic     hold_trigger = 1'b0;

    // sequencer state as the block should hold it
    logic [15:0]                   half_ticks = i2cms_pkg::HALF_PERIOD_RESET;
    logic [i2cms_pkg::PHASE_W-1:0] seq_phase = i2cms_pkg::PH_IDLE;
    logic [3:0]                    seq_bits = '0;
    logic [7:0]                    seq_shift = '0;
    logic [15:0]                   seq_wait = '0;
    i2cms_pkg::t_mode              seq_mode = i2cms_pkg::MODE_START;
    logic                          seq_ack = 1'b0;
    logic                          seq_scl_low = 1'b0;
    logic                          seq_sda_low = 1'b0;
    logic [7:0]                    seq_last_read = '0;

    function automatic void reload_wait();
        seq_wait = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    endfunction

    function automatic bit wait_expired();
        if (seq_wait <= 16'd1) begin
            seq_wait = '0;
            return 1'b1;
        end
        seq_wait = seq_wait - 16'd1;
        return 1'b0;
    endfunction

    function automatic bit reading_data();
        return seq_mode == i2cms_pkg::MODE_READ && seq_bits <= i2cms_pkg::LAST_DATA_BIT;
    endfunction

    // value put on SDA for a driven bit: data for a write, ack/nack after a read
    function automatic bit out_bit();
        if (seq_mode == i2cms_pkg::MODE_READ)
            return !seq_ack;
        return seq_shift[7];
    endfunction

    function automatic void start_bit();
        seq_sda_low = reading_data() ? 1'b0 : !out_bit();
        seq_scl_low = 1'b0;
        seq_phase = i2cms_pkg::PH_STRETCH;
    endfunction

    function automatic bit finish_bit();
        logic [3:0] lim;
        lim = (seq_mode == i2cms_pkg::MODE_READ) ? i2cms_pkg::BITS_READ
                                                 : i2cms_pkg::BITS_WRITE;
        seq_bits = seq_bits + 4'd1;
        if (seq_bits >= lim) begin
            seq_phase = i2cms_pkg::PH_IDLE;
            return 1'b1;
        end
        start_bit();
        return 1'b0;
    endfunction

    task automatic advance_sequencer(input t_tick t);
        t_bus_res r;
        logic     done;
        done = 1'b0;
        case (seq_phase)
            i2cms_pkg::PH_IDLE: begin
                if (t.cmd_valid) begin
                    seq_mode = t.mode;
                    seq_ack = t.send_ack;
                    seq_bits = '0;
                    case (t.mode)
                        i2cms_pkg::MODE_START: begin
                            seq_scl_low = 1'b0;
                            seq_sda_low = 1'b0;
                            reload_wait();
                            seq_phase = i2cms_pkg::PH_ST_REL;
                        end
                        i2cms_pkg::MODE_STOP: begin
                            seq_scl_low = 1'b0;
                            seq_sda_low = 1'b1;
                            reload_wait();
                            seq_phase = i2cms_pkg::PH_SP_HI;
                        end
                        default: begin
                            seq_shift = (t.mode == i2cms_pkg::MODE_WRITE) ? t.wdata : 8'h00;
                            start_bit();
                        end
                    endcase
                end
            end
            i2cms_pkg::PH_ST_REL: begin
                if (wait_expired()) begin
                    seq_sda_low = 1'b1;
                    reload_wait();
                    seq_phase = i2cms_pkg::PH_ST_SDA;
                end
            end
            i2cms_pkg::PH_ST_SDA: begin
                if (wait_expired()) begin
                    seq_scl_low = 1'b1;
                    reload_wait();
                    seq_phase = i2cms_pkg::PH_ST_SCL;
                end
            end
            i2cms_pkg::PH_ST_SCL, i2cms_pkg::PH_SP_REL: begin
                if (wait_expired()) begin
                    seq_phase = i2cms_pkg::PH_IDLE;
                    done = 1'b1;
                end
            end
            i2cms_pkg::PH_SP_HI: begin
                if (wait_expired()) begin
                    seq_sda_low = 1'b0;
                    reload_wait();
                    seq_phase = i2cms_pkg::PH_SP_REL;
                end
            end
            i2cms_pkg::PH_STRETCH: begin
                // hold while the slave keeps SCL low
                if (t.scl) begin
                    reload_wait();
                    seq_phase = i2cms_pkg::PH_HIGH;
                end
            end
            i2cms_pkg::PH_HIGH: begin
                if (wait_expired()) begin
                    if (reading_data()) begin
                        seq_shift = {seq_shift[6:0], t.sda};
                        if (seq_bits == i2cms_pkg::LAST_DATA_BIT)
                            seq_last_read = seq_shift;
                    end
                    seq_scl_low = 1'b1;
                    reload_wait();
                    seq_phase = i2cms_pkg::PH_LOW1;
                end
            end
            i2cms_pkg::PH_LOW1: begin
                if (wait_expired()) begin
                    if (reading_data()) begin
                        done = finish_bit();
                    end else begin
                        if (out_bit())
                            seq_sda_low = 1'b1;
                        reload_wait();
                        seq_phase = i2cms_pkg::PH_LOW2;
                    end
                end
            end
            i2cms_pkg::PH_LOW2: begin
                if (wait_expired()) begin
                    if (seq_mode == i2cms_pkg::MODE_WRITE)
                        seq_shift = {seq_shift[6:0], 1'b0};
                    done = finish_bit();
                end
            end
            default: seq_phase = i2cms_pkg::PH_IDLE;
        endcase
        r.scl_low = seq_scl_low;
        r.sda_low = seq_sda_low;
        r.busy = (seq_phase != i2cms_pkg::PH_IDLE);
        r.rdata = seq_last_read;
        r.done = done;
        bus_res_q.push_back(r);
    endtask

    // driver: present one tick per transaction, idling at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                advance_sequencer(cur_tick);
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_tick = tick_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd_valid <= cur_tick.cmd_valid;
                    i_mode <= cur_tick.mode;
                    i_write_data <= cur_tick.wdata;
                    i_send_ack <= cur_tick.send_ack;
                    i_scl_in <= cur_tick.scl;
                    i_sda_in <= cur_tick.sda;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_bus_res want;
        t_bus_res got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.scl_low = o_scl_drive_low;
            got.sda_low = o_sda_drive_low;
            got.busy = o_busy_res;
            got.rdata = o_read_data;
            got.done = o_cmd_done;
            if (bus_res_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result transaction at cycle %0d", cycles);
                mismatches++;
            end else begin
                want = bus_res_q.pop_front();
                if (want.scl_low !== got.scl_low || want.sda_low !== got.sda_low ||
                    want.busy !== got.busy || want.rdata !== got.rdata ||
                    want.done !== got.done) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch at cycle %0d (exp/act): scl_low %0b/%0b ",
                                  "sda_low %0b/%0b busy %0b/%0b read %02h/%02h done %0b/%0b"},
                                 cycles, want.scl_low, got.scl_low, want.sda_low,
                                 got.sda_low, want.busy, got.busy, want.rdata, got.rdata,
                                 want.done, got.done);
                    mismatches++;
                end
            end
        end
        i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall so the block fills and backs up its input
    initial begin : long_hold
        wait (hold_trigger);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_tick(logic cv, i2cms_pkg::t_mode m, logic [7:0] wd,
                                      logic ack, logic scl, logic sda);
        t_tick t;
        t.cmd_valid = cv;
        t.mode = m;
        t.wdata = wd;
        t.send_ack = ack;
        t.scl = scl;
        t.sda = sda;
        tick_q.push_back(t);
    endfunction

    // upper bound on ticks a command stays busy without stretching
    function automatic int cmd_ticks(i2cms_pkg::t_mode m);
        int d;
        d = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
        case (m)
            i2cms_pkg::MODE_START: return 3 * d + 2;
            i2cms_pkg::MODE_STOP:  return 2 * d + 2;
            i2cms_pkg::MODE_WRITE: return 8 * (3 * d + 1) + 2;
            default:               return 9 * (3 * d + 1) + 2;
        endcase
    endfunction

    // one command, then enough ticks to finish it; the first ones may stretch
    // SCL or carry commands that the busy block must drop
    task automatic issue_cmd(i2cms_pkg::t_mode m, logic [7:0] wd, logic ack, int stretch,
                             int pokes, logic [1:0] sda_sel);
        int   n;
        logic sda;
        push_tick(1'b1, m, wd, ack, 1'b1, 1'($urandom_range(1)));
        n = cmd_ticks(m) + stretch;
        for (int k = 0; k < n; k++) begin
            case (sda_sel)
                SDA_LOW:  sda = 1'b0;
                SDA_HIGH: sda = 1'b1;
                default:  sda = 1'($urandom_range(1));
            endcase
            push_tick(k < pokes, i2cms_pkg::t_mode'($urandom_range(3)),
                      8'($urandom_range(255)), 1'($urandom_range(1)), k >= stretch, sda);
        end
    endtask

    task automatic random_ticks(int n);
        int k;
        int run;
        k = 0;
        while (k < n) begin
            if ($urandom_range(49) == 0) begin
                // a longer clock stretch by the slave
                run = $urandom_range(3, 15);
                repeat (run)
                    push_tick($urandom_range(99) < 25, i2cms_pkg::t_mode'($urandom_range(3)),
                              8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                              1'($urandom_range(1)));
                k += run;
            end else begin
                push_tick($urandom_range(99) < 25, i2cms_pkg::t_mode'($urandom_range(3)),
                          8'($urandom_range(255)), 1'($urandom_range(1)),
                          $urandom_range(99) < 90, 1'($urandom_range(1)));
                k++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || bus_res_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_half_period(logic [15:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        half_ticks = v;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset delay in effect
        issue_cmd(i2cms_pkg::MODE_START, 8'h00, 1'b0, 0, 0, SDA_RAND);

        // zero delay acts as one tick
        write_half_period(16'h0000);
        issue_cmd(i2cms_pkg::MODE_START, 8'h00, 1'b0, 0, 2, SDA_RAND);
        issue_cmd(i2cms_pkg::MODE_WRITE, 8'hFF, 1'b1, 0, 0, SDA_RAND);
        issue_cmd(i2cms_pkg::MODE_WRITE, 8'h00, 1'b0, 6, 3, SDA_RAND);
        issue_cmd(i2cms_pkg::MODE_WRITE, 8'h81, 1'b1, 0, 0, SDA_RAND);
        issue_cmd(i2cms_pkg::MODE_READ, 8'hFF, 1'b1, 0, 0, SDA_HIGH);
        issue_cmd(i2cms_pkg::MODE_READ, 8'h00, 1'b0, 4, 2, SDA_LOW);
        issue_cmd(i2cms_pkg::MODE_READ, 8'h5A, 1'b1, 0, 0, SDA_RAND);
        issue_cmd(i2cms_pkg::MODE_STOP, 8'hFF, 1'b1, 0, 0, SDA_RAND);

        write_half_period(16'h0001);
        random_ticks(200);

        write_half_period(16'h0002);
        send_idle_pct = 82;
        recv_idle_pct = 22;
        random_ticks(200);

        write_half_period(16'h0003);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_ticks(250);
        hold_trigger = 1'b1;

        // longest delay: a stop command, watched for a short while
        write_half_period(16'hFFFF);
        push_tick(1'b1, i2cms_pkg::MODE_STOP, 8'h00, 1'b0, 1'b1, 1'($urandom_range(1)));
        random_ticks(20);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (bus_res_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- i2c_master_bit_sequencer.f -----
sv/i2cms_pkg.sv
sv/i2c_master_bit_sequencer.sv
sv/i2cms_checker.sv
sim/tb.sv
